// ===== src/sphere_flag_frame_assert.svh =====
// Assertion macros for the sphere flag frame block
`ifndef SPHERE_FLAG_FRAME_ASSERT_SVH
`define SPHERE_FLAG_FRAME_ASSERT_SVH

// clocked, disabled while in reset
`define SFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked, checked during reset too
`define SFF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/sff_pkg.sv =====
// Shared constants and types for the sphere flag frame block
package sff_pkg;

  localparam int          FracBits       = 16;
  localparam logic [31:0] IntensityReset = 32'(5) << FracBits;
  localparam int          RootW          = 32;
  localparam int          QuotW          = 32;
  localparam logic [2:0]  RegIntensity   = 3'd0;
  localparam logic [31:0] Max32          = 32'h7fff_ffff;
  localparam logic [31:0] Min32          = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_ROOT = 2'd1,
    ST_ZERO_DIR = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] ww;
    logic [31:0] z;
    logic        neg;
    logic        xy0;
    logic        dxneg;
    logic        dyneg;
  } side_t;

  typedef struct packed {
    side_t       sd;
    logic [63:0] px;
    logic [63:0] py;
  } sq_side_t;

  typedef struct packed {
    side_t       sd;
    logic [31:0] h;
  } dv_side_t;

endpackage

// ===== src/sff_isqrt.sv =====
// Pipelined floor square root, one root bit per stage, several lanes
module sff_isqrt import sff_pkg::*; #(
  parameter int RW    = RootW,
  parameter int LANES = 2,
  parameter int SW    = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*RW-1:0]   rad_i  [LANES],
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [RW-1:0]     root_o [LANES],
  output logic [SW-1:0]     side_o
);

  logic [2*RW-1:0] rad_s  [1:RW-1][LANES];
  logic [RW+1:0]   rem_s  [1:RW-1][LANES];
  logic [RW-1:0]   root_s [1:RW][LANES];
  logic            v_s    [1:RW];
  logic [SW-1:0]   side_s [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic          v_c;
    logic [SW-1:0] side_c;
    if (k == 0) begin : g_src0
      assign v_c    = valid_i;
      assign side_c = side_i;
    end else begin : g_srck
      assign v_c    = v_s[k];
      assign side_c = side_s[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_s[k+1] <= side_c;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_ln
      logic [2*RW-1:0] rad_c;
      logic [RW+1:0]   rem_c, rem_sh, trial;
      logic [RW-1:0]   root_c;
      logic            ge;
      if (k == 0) begin : g_src0
        assign rad_c  = rad_i[l];
        assign rem_c  = '0;
        assign root_c = '0;
      end else begin : g_srck
        assign rad_c  = rad_s[k][l];
        assign rem_c  = rem_s[k][l];
        assign root_c = root_s[k][l];
      end
      assign rem_sh = {rem_c[RW-1:0], rad_c[2*RW-1 -: 2]};
      assign trial  = {root_c, 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          root_s[k+1][l] <= {root_c[RW-2:0], ge};
        end
      end

      if (k < RW - 1) begin : g_carry
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rad_s[k+1][l] <= rad_c << 2;
            rem_s[k+1][l] <= ge ? rem_sh - trial : rem_sh;
          end
        end
      end
    end
  end

  assign valid_o = v_s[RW];
  assign side_o  = side_s[RW];
  assign root_o  = root_s[RW];

endmodule

// ===== src/sff_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, shared divisor
module sff_div import sff_pkg::*; #(
  parameter int QW    = QuotW,
  parameter int LANES = 2,
  parameter int SW    = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*QW-1:0] num_i  [LANES],
  input  logic [QW-1:0]   den_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [QW-1:0]   quo_o  [LANES],
  output logic [SW-1:0]   side_o
);

  logic [QW-1:0] rem_s [1:QW-1][LANES];
  logic [QW-1:0] low_s [1:QW-1][LANES];
  logic [QW-1:0] quo_s [1:QW][LANES];
  logic [QW-1:0] den_s [1:QW-1];
  logic          v_s   [1:QW];
  logic [SW-1:0] side_s[1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic          v_c;
    logic [SW-1:0] side_c;
    logic [QW-1:0] den_c;
    if (k == 0) begin : g_src0
      assign v_c    = valid_i;
      assign side_c = side_i;
      assign den_c  = den_i;
    end else begin : g_srck
      assign v_c    = v_s[k];
      assign side_c = side_s[k];
      assign den_c  = den_s[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_s[k+1] <= side_c;
      end
    end

    if (k < QW - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_s[k+1] <= den_c;
        end
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_ln
      logic [QW-1:0] rem_c, low_c, quo_c;
      logic [QW:0]   r, diff;
      logic          ge;
      if (k == 0) begin : g_src0
        assign rem_c = num_i[l][2*QW-1:QW];
        assign low_c = num_i[l][QW-1:0];
        assign quo_c = '0;
      end else begin : g_srck
        assign rem_c = rem_s[k][l];
        assign low_c = low_s[k][l];
        assign quo_c = quo_s[k][l];
      end
      assign r    = {rem_c, low_c[QW-1]};
      assign diff = r - {1'b0, den_c};
      assign ge   = r >= {1'b0, den_c};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_s[k+1][l] <= {quo_c[QW-2:0], ge};
        end
      end

      if (k < QW - 1) begin : g_carry
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_s[k+1][l] <= ge ? diff[QW-1:0] : r[QW-1:0];
            low_s[k+1][l] <= low_c << 1;
          end
        end
      end
    end
  end

  assign valid_o = v_s[QW];
  assign side_o  = side_s[QW];
  assign quo_o   = quo_s[QW];

endmodule

// ===== src/sphere_flag_frame.sv =====
// Top level of the sphere flag frame block
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      center_x, center_y, center_z, radius
//  m_axis    out  m_axis_tvalid/tready      frame fields and status
//  apb       in   psel/penable/pready       intensity register at address 0
//
// One sphere per cycle while the output is not stalled; the input transfer loads the first
// of 7 front stages (abs, squares, normalize, products), then a 32-stage square root,
// a 32-stage divider and the output register, which drives the output valid.
// All stages advance together whenever the output register is empty or taken;
// a stall freezes the whole pipeline, nothing is dropped or repeated.
// Reset clears valid bits and loads intensity with 5.0.
module sphere_flag_frame import sff_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // center_x[31:0], center_y[63:32], center_z[95:64], radius[126:96], pad
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // width_x, width_y, width_w, height_z, dir_x, dir_y, origin_z (32 each), status[225:224]
  output logic [231:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  function automatic logic [31:0] sat_dbl(input logic [31:0] v);
    logic [31:0] res;
    if (v[31] != v[30]) begin
      res = v[31] ? Min32 : Max32;
    end else begin
      res = {v[30:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic [31:0] dir_val(input logic [31:0] q, input logic neg);
    logic [31:0] qc, res;
    qc = (q > Min32) ? Min32 : q;
    if (neg) begin
      res = 32'(-qc);
    end else begin
      res = (qc == Min32) ? Max32 : qc;
    end
    return res;
  endfunction

  logic        en;
  logic [31:0] intensity_q, kmag;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == RegIntensity) ? intensity_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q <= IntensityReset;
    end else if (psel && penable && pwrite && pready && paddr == RegIntensity) begin
      intensity_q <= pwdata;
    end
  end

  assign kmag = intensity_q[31] ? 32'(-intensity_q) : intensity_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 0: input register
  logic        v0_q;
  logic [31:0] x0_q, y0_q, z0_q;
  logic [30:0] r0_q;

  // stage 1: magnitudes and squares
  logic        v1_q;
  logic [31:0] x1_q, y1_q, z1_q, ax1_q, ay1_q;
  logic [30:0] r1_q;
  logic [63:0] axsq1_q, aysq1_q;
  logic [61:0] rsq1_q;
  logic [31:0] ax_d, ay_d;

  // stage 2..6
  logic        v2_q, v3_q, v4_q, v5_q, v6_q;
  side_t       sd_d, sd2_q, sd3_q, sd4_q, sd5_q, sd6_q;
  logic [63:0] arg2_q, arg3_q, arg4_q, arg5_q, arg6_q, hsq_d;
  logic [31:0] ax2_q, ay2_q, nx3_q, ny3_q, nx4_q, ny4_q;
  logic [31:0] o16, nx16, ny16, nx8, ny8, o8, o4, o2, nx4, ny4, nx2, ny2, nx1, ny1;
  logic [63:0] px5_q, py5_q, nxsq5_q, nysq5_q, px6_q, py6_q, sum6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  assign ax_d  = x0_q[31] ? 32'(-x0_q) : x0_q;
  assign ay_d  = y0_q[31] ? 32'(-y0_q) : y0_q;
  assign hsq_d = axsq1_q + aysq1_q;

  always_comb begin
    sd_d.wx    = sat_dbl(x1_q);
    sd_d.wy    = sat_dbl(y1_q);
    sd_d.ww    = r1_q[30] ? Max32 : {r1_q, 1'b0};
    sd_d.z     = z1_q;
    sd_d.neg   = hsq_d > {2'b00, rsq1_q};
    sd_d.xy0   = (ax1_q | ay1_q) == '0;
    sd_d.dxneg = (!y1_q[31] && y1_q != '0) != intensity_q[31];
    sd_d.dyneg = x1_q[31] != intensity_q[31];
  end

  // normalize so that the larger magnitude has its top bit at 30 or 31
  always_comb begin
    o16  = ax2_q | ay2_q;
    nx16 = (o16 < 32'h0000_8000) ? ax2_q << 16 : ax2_q;
    ny16 = (o16 < 32'h0000_8000) ? ay2_q << 16 : ay2_q;
    o8   = nx16 | ny16;
    nx8  = (o8 < 32'h0080_0000) ? nx16 << 8 : nx16;
    ny8  = (o8 < 32'h0080_0000) ? ny16 << 8 : ny16;
    o4   = nx3_q | ny3_q;
    nx4  = (o4 < 32'h0800_0000) ? nx3_q << 4 : nx3_q;
    ny4  = (o4 < 32'h0800_0000) ? ny3_q << 4 : ny3_q;
    o2   = nx4 | ny4;
    nx2  = (o2 < 32'h2000_0000) ? nx4 << 2 : nx4;
    ny2  = (o2 < 32'h2000_0000) ? ny4 << 2 : ny4;
    nx1  = ((nx2 | ny2) < 32'h4000_0000) ? nx2 << 1 : nx2;
    ny1  = ((nx2 | ny2) < 32'h4000_0000) ? ny2 << 1 : ny2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q    <= s_axis_tdata[31:0];
      y0_q    <= s_axis_tdata[63:32];
      z0_q    <= s_axis_tdata[95:64];
      r0_q    <= s_axis_tdata[126:96];
      x1_q    <= x0_q;
      y1_q    <= y0_q;
      z1_q    <= z0_q;
      r1_q    <= r0_q;
      ax1_q   <= ax_d;
      ay1_q   <= ay_d;
      axsq1_q <= ax_d * ax_d;
      aysq1_q <= ay_d * ay_d;
      rsq1_q  <= r0_q * r0_q;
      sd2_q   <= sd_d;
      arg2_q  <= {2'b00, rsq1_q} - hsq_d;
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      sd3_q   <= sd2_q;
      arg3_q  <= arg2_q;
      nx3_q   <= nx8;
      ny3_q   <= ny8;
      sd4_q   <= sd3_q;
      arg4_q  <= arg3_q;
      nx4_q   <= nx1;
      ny4_q   <= ny1;
      sd5_q   <= sd4_q;
      arg5_q  <= arg4_q;
      nxsq5_q <= nx4_q * nx4_q;
      nysq5_q <= ny4_q * ny4_q;
      px5_q   <= nx4_q * kmag;
      py5_q   <= ny4_q * kmag;
      sd6_q   <= sd5_q;
      arg6_q  <= arg5_q;
      sum6_q  <= nxsq5_q + nysq5_q;
      px6_q   <= px5_q;
      py6_q   <= py5_q;
    end
  end

  // half height and direction length
  logic [2*RootW-1:0] rad   [2];
  logic [RootW-1:0]   roots [2];
  sq_side_t           sq_in, sq_out;
  logic               sq_valid;

  assign rad[0]   = arg6_q;
  assign rad[1]   = sum6_q;
  assign sq_in.sd = sd6_q;
  assign sq_in.px = px6_q;
  assign sq_in.py = py6_q;

  sff_isqrt #(
    .RW    (RootW),
    .LANES (2),
    .SW    ($bits(sq_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .rad_i   (rad),
    .side_i  (sq_in),
    .valid_o (sq_valid),
    .root_o  (roots),
    .side_o  (sq_out)
  );

  // direction quotients
  logic [2*QuotW-1:0] num [2];
  logic [QuotW-1:0]   quo [2];
  dv_side_t           dv_in, dv_out;
  logic               dv_valid;

  assign num[0]   = sq_out.py;
  assign num[1]   = sq_out.px;
  assign dv_in.sd = sq_out.sd;
  assign dv_in.h  = roots[0];

  sff_div #(
    .QW    (QuotW),
    .LANES (2),
    .SW    ($bits(dv_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .num_i   (num),
    .den_i   (roots[1]),
    .side_i  (dv_in),
    .valid_o (dv_valid),
    .quo_o   (quo),
    .side_o  (dv_out)
  );

  // output register
  logic        m_valid_q;
  logic [31:0] wx_q, wy_q, ww_q, height_q, dx_q, dy_q, origin_q;
  logic [31:0] height_d, dx_d, dy_d, origin_d;
  logic [32:0] od;
  status_e     status_q, status_d;

  always_comb begin
    od = {dv_out.sd.z[31], dv_out.sd.z} - {1'b0, dv_out.h};
    if (dv_out.sd.neg) begin
      status_d = ST_NEG_ROOT;
    end else if (dv_out.h == '0 || dv_out.sd.xy0) begin
      status_d = ST_ZERO_DIR;
    end else begin
      status_d = ST_OK;
    end
    height_d = dv_out.h[30] ? Max32 : {dv_out.h[30:0], 1'b0};
    origin_d = (od[32] != od[31]) ? (od[32] ? Min32 : Max32) : od[31:0];
    dx_d     = dir_val(quo[0], dv_out.sd.dxneg);
    dy_d     = dir_val(quo[1], dv_out.sd.dyneg);
    if (status_d == ST_NEG_ROOT) begin
      height_d = '0;
      origin_d = '0;
    end
    if (status_d != ST_OK) begin
      dx_d = '0;
      dy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q     <= dv_out.sd.wx;
      wy_q     <= dv_out.sd.wy;
      ww_q     <= dv_out.sd.ww;
      height_q <= height_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      origin_q <= origin_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, status_q, origin_q, dy_q, dx_q, height_q, ww_q, wy_q, wx_q};

endmodule

// ===== src/sff_checker.sv =====
// Port-level checks for the sphere flag frame block, with bind
`include "sphere_flag_frame_assert.svh"

module sff_checker import sff_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [231:0] m_axis_tdata,
  input logic         pready
);

  `SFF_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

  `SFF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")

  `SFF_ASSERT(a_neg_root_clear, m_axis_tvalid && m_axis_tdata[225:224] == ST_NEG_ROOT |-> m_axis_tdata[223:96] == '0, "root error fields not cleared")

  `SFF_ASSERT(a_zero_dir_clear, m_axis_tvalid && m_axis_tdata[225:224] == ST_ZERO_DIR |-> m_axis_tdata[191:128] == '0, "direction not cleared")

endmodule

bind sphere_flag_frame sff_checker u_sff_checker (.*);
